>>> hdl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// shared types, codes and character constants for integer to ascii conversion
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int VALUE_W   = 64;
    localparam int NDIGITS   = 20;
    localparam int DIGITS_W  = NDIGITS * 4;

    typedef logic [3:0] digit_t;
    typedef logic [7:0] char_t;

    localparam logic [1:0] CONV_SDEC = 2'd0;
    localparam logic [1:0] CONV_UDEC = 2'd1;
    localparam logic [1:0] CONV_HEX  = 2'd2;

    localparam char_t CHAR_MINUS = 8'h2d;
    localparam char_t CHAR_ZERO  = 8'h30;
    localparam char_t CHAR_NINE  = 8'h39;
    localparam char_t CHAR_LC_A  = 8'h61;
    localparam char_t CHAR_LC_F  = 8'h66;

    // digit to lower-case ascii
    function automatic char_t digit_char(input digit_t d);
        char_t c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + {4'd0, d};
        end
        else
        begin
            c = CHAR_LC_A + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

>>> hdl/integer_to_ascii_dec_hex.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_dec_hex
// integer to decimal or hex ascii text, one character per result strobe
// ----------------------------------------------------------------------------
// sequence: decimal runs the shift-add-3 conversion, emits a minus sign if negative,
//   then drops leading zero digits and emits the rest; hex skips the shift-add-3
// a new request is taken only while idle; start is ignored while busy
// busy drops as the last character is registered; the receiver cannot stall
// reset: asynchronous, active low; clears the sequencer and the strobe
// ----------------------------------------------------------------------------
module integer_to_ascii_dec_hex
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] value,
    input  logic [1:0]  conversion,
    input  logic        arg_width,
    output logic        valid,
    output logic [7:0]  char_code,
    output logic        last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SIGN = 3'd2;
    localparam logic [2:0] ST_SKIP = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]                        state_reg, state_next;
    logic [itoa_pkg::VALUE_W-1:0]      bin_reg, bin_next;
    logic [itoa_pkg::DIGITS_W-1:0]     dig_reg, dig_next;
    logic [5:0]                        bit_cnt_reg, bit_cnt_next;
    logic [4:0]                        rem_reg, rem_next;
    logic                              neg_reg, neg_next;
    logic                              valid_reg, valid_next;
    itoa_pkg::char_t                   char_reg, char_next;
    logic                              last_reg, last_next;

    logic [itoa_pkg::VALUE_W-1:0]      ext_val;
    logic [itoa_pkg::VALUE_W-1:0]      mag_val;
    logic                              in_neg;
    logic [itoa_pkg::DIGITS_W-1:0]     dig_adj;
    itoa_pkg::digit_t                  top_digit;

    // width cut and sign handling
    always_comb
    begin
        if (arg_width)
        begin
            ext_val = value;
        end
        else if (conversion == itoa_pkg::CONV_SDEC)
        begin
            ext_val = {{32{value[31]}}, value[31:0]};
        end
        else
        begin
            ext_val = {32'd0, value[31:0]};
        end
        in_neg  = (conversion == itoa_pkg::CONV_SDEC) && ext_val[63];
        mag_val = in_neg ? (64'd0 - ext_val) : ext_val;
    end

    // shared add-3 correction over all bcd digits
    always_comb
    begin
        for (int i = 0; i < itoa_pkg::NDIGITS; i++)
        begin
            if (dig_reg[i*4 +: 4] >= 4'd5)
            begin
                dig_adj[i*4 +: 4] = dig_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                dig_adj[i*4 +: 4] = dig_reg[i*4 +: 4];
            end
        end
    end

    assign top_digit = dig_reg[itoa_pkg::DIGITS_W-1 -: 4];

    always_comb
    begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        dig_next     = dig_reg;
        bit_cnt_next = bit_cnt_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        valid_next   = 1'b0;
        char_next    = char_reg;
        last_next    = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    neg_next     = in_neg;
                    bin_next     = mag_val;
                    dig_next     = {16'd0, mag_val};
                    bit_cnt_next = 6'd0;
                    rem_next     = 5'(itoa_pkg::NDIGITS);
                    if (conversion[1])
                    begin
                        state_next = ST_SKIP;
                    end
                    else
                    begin
                        dig_next   = '0;
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                dig_next     = {dig_adj[itoa_pkg::DIGITS_W-2:0], bin_reg[63]};
                bin_next     = {bin_reg[62:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 6'd1;
                if (bit_cnt_reg == 6'd63)
                begin
                    state_next = neg_reg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN:
            begin
                valid_next = 1'b1;
                char_next  = itoa_pkg::CHAR_MINUS;
                last_next  = 1'b0;
                state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                if ((top_digit == 4'd0) && (rem_reg > 5'd1))
                begin
                    dig_next = {dig_reg[itoa_pkg::DIGITS_W-5:0], 4'd0};
                    rem_next = rem_reg - 5'd1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                valid_next = 1'b1;
                char_next  = itoa_pkg::digit_char(top_digit);
                last_next  = (rem_reg == 5'd1);
                dig_next   = {dig_reg[itoa_pkg::DIGITS_W-5:0], 4'd0};
                rem_next   = rem_reg - 5'd1;
                if (rem_reg == 5'd1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg     <= bin_next;
        dig_reg     <= dig_next;
        bit_cnt_reg <= bit_cnt_next;
        rem_reg     <= rem_next;
        neg_reg     <= neg_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign valid     = valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

endmodule

>>> hdl/itoa_chk.sv
// ----------------------------------------------------------------------------
// itoa_chk
// port-level checks for the integer to ascii converter
// ----------------------------------------------------------------------------
module itoa_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [63:0] value,
    input logic [1:0]  conversion,
    input logic        arg_width,
    input logic        valid,
    input logic [7:0]  char_code,
    input logic        last
);

    // accepted request makes the block busy
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but busy not raised");

    // more characters follow a non-final one, so the block stays busy
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last |-> busy)
        else $error("non-final character while idle");

    // final character is never followed directly by another
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last |=> !valid)
        else $error("character right after final character");

    // only sign, decimal digits or lower-case hex digits
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (char_code == itoa_pkg::CHAR_MINUS)
               || ((char_code >= itoa_pkg::CHAR_ZERO) && (char_code <= itoa_pkg::CHAR_NINE))
               || ((char_code >= itoa_pkg::CHAR_LC_A) && (char_code <= itoa_pkg::CHAR_LC_F)))
        else $error("character outside the output set");

    // a sign is always followed by digits
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (char_code == itoa_pkg::CHAR_MINUS) |-> !last)
        else $error("sign marked as final character");

endmodule

bind integer_to_ascii_dec_hex itoa_chk u_itoa_chk (.*);
